>>> src/sbbl_pkg.sv
// ----------------------------------------------------------------------------
// sbbl_pkg
// shared types and constants of the static search-tree bracket lookup
// ----------------------------------------------------------------------------
package sbbl_pkg;

  // command codes of an input item
  localparam logic [1:0] FUNC_WR_NODE = 2'd0;
  localparam logic [1:0] FUNC_WR_LEAF = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP  = 2'd2;

  localparam int unsigned NUM_LEVELS_W = 3;
  localparam int unsigned KEYS_PER_NODE = 8;
  localparam int unsigned KEY_CNT_W = 4;    // holds 0..8
  localparam int unsigned KEY_IDX_W = 3;    // holds 0..7

  // leaf block layout: eight keys then eight values
  localparam logic [4:0] NODE_CHILD_OFF = 5'd8;
  localparam logic signed [5:0] LEAF_PREV_OFF = -6'sd1;
  localparam logic signed [5:0] LEAF_VAL_OFF = 6'sd8;
  localparam logic signed [5:0] LEAF_LAST_OFF = 6'sd15;
  localparam logic signed [5:0] LEAF_NEXT_OFF = 6'sd24;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  level;
    logic [13:0] address;
    logic [63:0] data;
    logic [63:0] query;
  } item_in_t;

  typedef struct packed {
    logic [63:0] lower_value;
    logic [63:0] upper_value;
    logic        out_of_range;
  } item_out_t;

  // kind of store read issued in a cycle
  typedef enum logic [2:0] {
    RD_NONE,
    RD_NODE_KEY,
    RD_NODE_CHILD,
    RD_LEAF_KEY,
    RD_LEAF_LO,
    RD_LEAF_HI
  } rd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NODE_KEY,
    S_NODE_CHILD,
    S_NODE_WAIT,
    S_LEAF_KEY,
    S_LEAF_LO,
    S_LEAF_HI,
    S_LEAF_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic wr_node;
    logic wr_leaf;
    rd_e  rd;
  } dp_cmd_t;

  typedef struct packed {
    logic k_last;
    logic no_levels;
    logic last_level;
  } dp_stat_t;

endpackage

>>> src/static_btree_bracket_lookup_top.sv
// ----------------------------------------------------------------------------
// static_btree_bracket_lookup_top
// static eight-way search tree with a bracketing leaf lookup
// ----------------------------------------------------------------------------
// A write item (func 0 or 1) is stored at the accepting edge and gives no
// result; busy stays low. A lookup item walks num_levels (at most MAX_LEVELS)
// internal levels and then one leaf block, reading at most one 64-bit word a
// cycle from the node store, then the leaf store: each level steps through 8
// keys, child slot and child return, the leaf through 8 keys, two values and
// return; then the strobe done_o rises and a new item can be accepted in that
// strobe cycle. The result sits on res_o for exactly that one cycle and the
// receiver cannot stall it, so it must take it then. The user must see that
// num_levels is written through cfg_we_i only while idle; it is not enforced.
module static_btree_bracket_lookup_top #(
  parameter int unsigned MAX_LEVELS  = 4,
  parameter int unsigned LEVEL_WORDS = 4096,
  parameter int unsigned LEAF_WORDS  = 16384
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: num_levels
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_data_i,
  // item in
  input  logic                start,
  output logic                busy,
  input  sbbl_pkg::item_in_t  cmd_i,
  // result out, one-cycle strobe
  output logic                done_o,
  output sbbl_pkg::item_out_t res_o
);
  import sbbl_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: accept, read stepping, result strobe
  sbbl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (cmd_i.func),
    .stat_i (dp_stat),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (dp_cmd)
  );

  // stores, range checks, key counting and result registers
  sbbl_dp #(
    .MAX_LEVELS  (MAX_LEVELS),
    .LEVEL_WORDS (LEVEL_WORDS),
    .LEAF_WORDS  (LEAF_WORDS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (cmd_i),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .res_o      (res_o)
  );

endmodule

>>> src/sbbl_ctrl.sv
// ----------------------------------------------------------------------------
// sbbl_ctrl
// sequencer of the lookup: steps node, leaf and value reads one word a cycle
// ----------------------------------------------------------------------------
module sbbl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [1:0]       func_i,
  input  sbbl_pkg::dp_stat_t stat_i,
  output logic             busy,
  output logic             done_o,
  output sbbl_pkg::dp_cmd_t  cmd_o
);
  import sbbl_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign busy   = (state_q != S_IDLE) && (state_q != S_DONE);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE, S_DONE: begin
        if (accept && func_i == FUNC_LOOKUP) begin
          state_d = stat_i.no_levels ? S_LEAF_KEY : S_NODE_KEY;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_NODE_KEY: begin
        if (stat_i.k_last) state_d = S_NODE_CHILD;
      end
      S_NODE_CHILD: state_d = S_NODE_WAIT;
      S_NODE_WAIT:  state_d = stat_i.last_level ? S_LEAF_KEY : S_NODE_KEY;
      S_LEAF_KEY: begin
        if (stat_i.k_last) state_d = S_LEAF_LO;
      end
      S_LEAF_LO:   state_d = S_LEAF_HI;
      S_LEAF_HI:   state_d = S_LEAF_WAIT;
      S_LEAF_WAIT: state_d = S_DONE;
      default:     state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.start   = 1'b0;
    cmd_o.wr_node = accept && func_i == FUNC_WR_NODE;
    cmd_o.wr_leaf = accept && func_i == FUNC_WR_LEAF;
    cmd_o.rd      = RD_NONE;
    done_o        = 1'b0;
    unique case (state_q)
      S_IDLE: cmd_o.start = accept && func_i == FUNC_LOOKUP;
      S_DONE: begin
        cmd_o.start = accept && func_i == FUNC_LOOKUP;
        done_o      = 1'b1;
      end
      S_NODE_KEY:   cmd_o.rd = RD_NODE_KEY;
      S_NODE_CHILD: cmd_o.rd = RD_NODE_CHILD;
      S_LEAF_KEY:   cmd_o.rd = RD_LEAF_KEY;
      S_LEAF_LO:    cmd_o.rd = RD_LEAF_LO;
      S_LEAF_HI:    cmd_o.rd = RD_LEAF_HI;
      default:      cmd_o.rd = RD_NONE;
    endcase
  end

endmodule

>>> src/sbbl_dp.sv
// ----------------------------------------------------------------------------
// sbbl_dp
// datapath: node and leaf stores, address and range checks, key counting
// ----------------------------------------------------------------------------
module sbbl_dp #(
  parameter int unsigned MAX_LEVELS  = 4,
  parameter int unsigned LEVEL_WORDS = 4096,
  parameter int unsigned LEAF_WORDS  = 16384
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_data_i,
  input  sbbl_pkg::item_in_t  item_i,
  input  sbbl_pkg::dp_cmd_t   cmd_i,
  output sbbl_pkg::dp_stat_t  stat_o,
  output sbbl_pkg::item_out_t res_o
);
  import sbbl_pkg::*;

  localparam int unsigned LVB = $clog2(LEVEL_WORDS);
  localparam int unsigned LFB = $clog2(LEAF_WORDS);
  localparam int unsigned IAW = $clog2(MAX_LEVELS * LEVEL_WORDS);
  localparam int unsigned NODE_DEPTH = MAX_LEVELS * LEVEL_WORDS;

  logic [63:0] node_mem [NODE_DEPTH];
  logic [63:0] leaf_mem [LEAF_WORDS];

  logic [NUM_LEVELS_W-1:0] num_levels_q;
  logic [63:0]             query_q;
  logic [63:0]             idx_q, idx_d;
  logic [2:0]              lvl_q, lvl_d;
  logic [KEY_IDX_W-1:0]    k_q, k_d;
  logic [KEY_CNT_W-1:0]    cnt_q, cnt_d, cnt_now;
  rd_e                     kind_q;
  logic                    rd_ok_q, rd_ok_d;
  logic                    oob_q, oob_d;
  logic [63:0]             lo_q, hi_q;
  logic [63:0]             node_rdata_q, leaf_rdata_q;

  logic [3:0]  levels;
  logic [63:0] word;
  logic        hit;

  // node address path
  logic [4:0]     node_off;
  logic [LVB+1:0] node_sum;
  logic           node_ok;
  logic [31:0]    node_ra_w, node_wa_w;
  logic           node_re, node_we;

  // leaf address path
  logic signed [5:0]     leaf_off;
  logic signed [LFB+2:0] leaf_pos;
  logic                  leaf_ok;
  logic                  leaf_re, leaf_we;
  logic [31:0]           leaf_wa_w;

  // configured depth, held to the levels the store has
  assign levels = (4'(num_levels_q) > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : 4'(num_levels_q);

  assign stat_o.k_last     = (k_q == KEY_IDX_W'(KEYS_PER_NODE - 1));
  assign stat_o.no_levels  = (levels == 4'd0);
  assign stat_o.last_level = (4'(lvl_q) + 4'd1 == levels);

  // word returned by the read issued last cycle, zero when out of range
  always_comb begin
    word = 64'd0;
    if (rd_ok_q) begin
      word = (kind_q == RD_NODE_KEY || kind_q == RD_NODE_CHILD) ? node_rdata_q
                                                                : leaf_rdata_q;
    end
  end

  assign hit = (kind_q == RD_NODE_KEY && query_q > word) ||
               (kind_q == RD_LEAF_KEY && query_q >= word);
  assign cnt_now = cnt_q + KEY_CNT_W'(hit);

  // node read address: key k, or child slot after the keys
  assign node_off = (cmd_i.rd == RD_NODE_KEY) ? 5'(k_q) : NODE_CHILD_OFF + 5'(cnt_now);
  assign node_sum = (LVB+2)'(idx_q[LVB:0]) + (LVB+2)'(node_off);
  assign node_ok  = (idx_q[63:LVB+1] == '0) && (32'(node_sum) < 32'(LEVEL_WORDS));
  assign node_ra_w = 32'(lvl_q) * 32'(LEVEL_WORDS) + 32'(node_sum);
  assign node_re   = (cmd_i.rd == RD_NODE_KEY) || (cmd_i.rd == RD_NODE_CHILD);

  // leaf read offset, with the block-edge cases crossing to neighbor blocks
  always_comb begin
    leaf_off = 6'($signed({1'b0, k_q}));
    case (cmd_i.rd)
      RD_LEAF_LO: begin
        if (cnt_now == 4'd0) begin
          leaf_off = LEAF_PREV_OFF;
        end else if (cnt_now == KEY_CNT_W'(KEYS_PER_NODE)) begin
          leaf_off = LEAF_LAST_OFF;
        end else begin
          leaf_off = LEAF_VAL_OFF - 6'sd1 + 6'($signed({2'b0, cnt_now}));
        end
      end
      RD_LEAF_HI: begin
        if (cnt_now == 4'd0) begin
          leaf_off = LEAF_VAL_OFF;
        end else if (cnt_now == KEY_CNT_W'(KEYS_PER_NODE)) begin
          leaf_off = LEAF_NEXT_OFF;
        end else begin
          leaf_off = LEAF_VAL_OFF + 6'($signed({2'b0, cnt_now}));
        end
      end
      default: leaf_off = 6'($signed({1'b0, k_q}));
    endcase
  end

  assign leaf_pos = $signed({2'b0, idx_q[LFB:0]}) + (LFB+3)'(leaf_off);
  assign leaf_ok  = (idx_q[63:LFB+1] == '0) && !leaf_pos[LFB+2] &&
                    (32'(leaf_pos[LFB+1:0]) < 32'(LEAF_WORDS));
  assign leaf_re  = (cmd_i.rd == RD_LEAF_KEY) || (cmd_i.rd == RD_LEAF_LO) ||
                    (cmd_i.rd == RD_LEAF_HI);

  // write decode
  assign node_we   = cmd_i.wr_node && (32'(item_i.level) < 32'(MAX_LEVELS)) &&
                     (32'(item_i.address) < 32'(LEVEL_WORDS));
  assign node_wa_w = 32'(item_i.level) * 32'(LEVEL_WORDS) + 32'(item_i.address);
  assign leaf_we   = cmd_i.wr_leaf && (32'(item_i.address) < 32'(LEAF_WORDS));
  assign leaf_wa_w = 32'(item_i.address);

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_wa_w[IAW-1:0]] <= item_i.data;
    if (node_re) node_rdata_q <= node_mem[node_ra_w[IAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (leaf_we) leaf_mem[leaf_wa_w[LFB-1:0]] <= item_i.data;
    if (leaf_re) leaf_rdata_q <= leaf_mem[leaf_pos[LFB-1:0]];
  end

  always_comb begin
    idx_d   = idx_q;
    lvl_d   = lvl_q;
    k_d     = k_q;
    cnt_d   = cnt_now;
    rd_ok_d = 1'b0;
    oob_d   = oob_q;
    if (node_re) rd_ok_d = node_ok;
    if (leaf_re) begin
      rd_ok_d = leaf_ok;
      oob_d   = oob_q | !leaf_ok;
    end
    if (cmd_i.rd == RD_NODE_KEY || cmd_i.rd == RD_LEAF_KEY) k_d = k_q + 1'b1;
    if (kind_q == RD_NODE_CHILD) begin
      idx_d = word;
      lvl_d = lvl_q + 3'd1;
      cnt_d = '0;
    end
    if (cmd_i.start) begin
      idx_d = '0;
      lvl_d = '0;
      k_d   = '0;
      cnt_d = '0;
      oob_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_levels_q <= '0;
      kind_q       <= RD_NONE;
      lvl_q        <= '0;
      k_q          <= '0;
      cnt_q        <= '0;
      rd_ok_q      <= 1'b0;
    end else begin
      if (cfg_we_i) num_levels_q <= cfg_data_i;
      kind_q  <= cmd_i.rd;
      lvl_q   <= lvl_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) query_q <= item_i.query;
    idx_q <= idx_d;
    oob_q <= oob_d;
    if (kind_q == RD_LEAF_LO) lo_q <= word;
    if (kind_q == RD_LEAF_HI) hi_q <= word;
  end

  assign res_o.lower_value  = lo_q;
  assign res_o.upper_value  = hi_q;
  assign res_o.out_of_range = oob_q;

endmodule
